>>> src/hcpg_pkg.sv
package hcpg_pkg;

  // Width of every coordinate in a result item.
  localparam int OUT_W = 11;

  // Result transfer data width: three coordinates, padded to whole bytes.
  localparam int OUT_TDATA_W = ((3 * OUT_W + 7) / 8) * 8;

  // Division by ten as a reciprocal multiply: floor(v / 10) == (v * 0xCCCD) >> 19,
  // exact for every v below 2**16.
  localparam int RECIP_W = 16;
  localparam logic [RECIP_W-1:0] DIV10_RECIP = 16'hCCCD;
  localparam int DIV10_SHIFT = 19;

  // Request kinds carried in the input tuser bit.
  typedef enum logic {
    REQ_START = 1'b0,
    REQ_STEP  = 1'b1
  } req_kind_t;

  // One result item.
  typedef struct packed {
    logic [OUT_W-1:0] right_x;
    logic [OUT_W-1:0] left_x;
    logic [OUT_W-1:0] point_y;
    logic             point_valid;
    logic             arc_done;
  } result_t;

endpackage

>>> src/hcpg_walker.sv
module hcpg_walker
  import hcpg_pkg::*;
#(
  parameter int COORD_BITS = 9
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  take,
  input  req_kind_t             req_type,
  input  logic [COORD_BITS-1:0] corner_left,
  input  logic [COORD_BITS-1:0] corner_bottom,
  input  logic [COORD_BITS-1:0] corner_right,
  input  logic [COORD_BITS-1:0] corner_top,
  input  logic                  mirrored,
  output result_t               result
);

  localparam int N   = COORD_BITS;
  localparam int SW  = N + 1;                      // step_y, signed
  localparam int EW  = N + 3;                      // error term, signed
  localparam int YW  = N + 4;                      // 7*y plus rounding bias
  localparam int PW  = YW + RECIP_W;               // reciprocal product
  localparam int QW  = PW - DIV10_SHIFT;           // scaled row offset
  localparam int RW  = (N + 5 > OUT_W) ? N + 5 : OUT_W;

  // Walk state.
  logic [N-1:0]          centre_x, centre_x_next;
  logic [N-1:0]          base_row, base_row_next;
  logic [N-1:0]          step_x, step_x_next;
  logic signed [SW-1:0]  step_y, step_y_next;
  logic signed [EW-1:0]  error_term, error_term_next;
  logic                  arc_mirrored, arc_mirrored_next;
  logic                  arc_active, arc_active_next;

  // Start decode.
  logic                  is_start;
  logic [N:0]            corner_sum;
  logic signed [N+1:0]   width_diff;
  logic                  radius_neg;
  logic [N-1:0]          radius;

  // Values the current item works on.
  logic [N-1:0]          cur_cx, cur_base, cur_sx;
  logic signed [SW-1:0]  cur_sy;
  logic signed [EW-1:0]  cur_err;
  logic                  cur_mir;
  logic                  emit;

  // Row scaling.
  logic [YW-1:0]         ys, ys_adj;
  logic [PW-1:0]         prod;
  logic [QW-1:0]         q;
  logic signed [RW-1:0]  cx_ext, sx_ext, base_ext, q_ext;
  logic signed [RW-1:0]  rx, lx, row;

  // Error walk.
  logic signed [EW-1:0]  sx_e, sy_e;
  logic                  go_x, go_y;
  logic [N-1:0]          adv_sx;
  logic signed [SW-1:0]  adv_sy;
  logic signed [EW-1:0]  adv_err;

  always_comb begin
    is_start   = (req_type == REQ_START);
    corner_sum = {1'b0, corner_left} + {1'b0, corner_right};
    width_diff = $signed({2'b00, corner_right}) - $signed({2'b00, corner_left});
    // The radius truncates toward zero, so a width of minus one still gives zero.
    radius_neg = width_diff < -2'sd1;
    radius     = width_diff[N+1] ? '0 : width_diff[N:1];

    if (is_start) begin
      cur_cx   = corner_sum[N:1];
      cur_base = mirrored ? corner_bottom : corner_top;
      cur_mir  = mirrored;
      cur_sx   = '0;
      cur_sy   = $signed({1'b0, radius});
      cur_err  = $signed(EW'(2)) - $signed({2'b00, radius, 1'b0});
      emit     = !radius_neg;
    end else begin
      cur_cx   = centre_x;
      cur_base = base_row;
      cur_mir  = arc_mirrored;
      cur_sx   = step_x;
      cur_sy   = step_y;
      cur_err  = error_term;
      emit     = arc_active;
    end

    // Row offset: ceil(7y/10) below the base or floor(7y/10) above it.
    ys     = {1'b0, cur_sy[N-1:0], 3'b000} - {4'b0000, cur_sy[N-1:0]};
    ys_adj = cur_mir ? ys : ys + YW'(9);
    prod   = {{RECIP_W{1'b0}}, ys_adj} * {{YW{1'b0}}, DIV10_RECIP};
    q      = prod[PW-1:DIV10_SHIFT];

    cx_ext   = $signed({{(RW-N){1'b0}}, cur_cx});
    sx_ext   = $signed({{(RW-N){1'b0}}, cur_sx});
    base_ext = $signed({{(RW-N){1'b0}}, cur_base});
    q_ext    = $signed({{(RW-QW){1'b0}}, q});
    rx       = cx_ext + sx_ext;
    lx       = cx_ext - sx_ext;
    row      = cur_mir ? base_ext + q_ext : base_ext - q_ext;

    // One Bresenham iteration.
    sx_e = $signed({3'b000, cur_sx});
    sy_e = {{(EW-SW){cur_sy[SW-1]}}, cur_sy};
    go_x = (cur_err < 0) && (cur_err + sy_e <= 0);
    go_y = (cur_err > 0) && (cur_err > sx_e);
    adv_sx  = cur_sx;
    adv_sy  = cur_sy;
    adv_err = cur_err;
    priority if (go_x) begin
      adv_sx  = cur_sx + N'(1);
      adv_err = cur_err + (sx_e <<< 1) + EW'(3);
    end else if (go_y) begin
      adv_sy  = cur_sy - SW'(1);
      adv_err = cur_err + EW'(3) - (sy_e <<< 1);
    end else begin
      adv_sx  = cur_sx + N'(1);
      adv_sy  = cur_sy - SW'(1);
      adv_err = cur_err + (sx_e <<< 1) + EW'(2) - (sy_e <<< 1);
    end

    centre_x_next     = centre_x;
    base_row_next     = base_row;
    arc_mirrored_next = arc_mirrored;
    step_x_next       = step_x;
    step_y_next       = step_y;
    error_term_next   = error_term;
    arc_active_next   = arc_active;
    if (is_start) begin
      centre_x_next     = cur_cx;
      base_row_next     = cur_base;
      arc_mirrored_next = cur_mir;
    end
    if (emit) begin
      step_x_next     = adv_sx;
      step_y_next     = adv_sy;
      error_term_next = adv_err;
      arc_active_next = !adv_sy[SW-1];
    end else if (is_start) begin
      step_x_next     = '0;
      step_y_next     = '0;
      error_term_next = '0;
      arc_active_next = 1'b0;
    end

    result.right_x     = emit ? rx[OUT_W-1:0] : '0;
    result.left_x      = emit ? lx[OUT_W-1:0] : '0;
    result.point_y     = emit ? row[OUT_W-1:0] : '0;
    result.point_valid = emit;
    result.arc_done    = emit ? adv_sy[SW-1] : 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      centre_x     <= '0;
      base_row     <= '0;
      step_x       <= '0;
      step_y       <= '0;
      error_term   <= '0;
      arc_mirrored <= 1'b0;
      arc_active   <= 1'b0;
    end else if (take) begin
      centre_x     <= centre_x_next;
      base_row     <= base_row_next;
      step_x       <= step_x_next;
      step_y       <= step_y_next;
      error_term   <= error_term_next;
      arc_mirrored <= arc_mirrored_next;
      arc_active   <= arc_active_next;
    end
  end

endmodule

>>> src/half_circle_point_generator.sv
// Channel  Dir  Handshake          Payload
// s_       in   s_tvalid/s_tready  s_tuser = req_type; s_tdata = corners and mirrored
// m_       out  m_tvalid/m_tready  m_tdata = x pair and row; m_tuser = point_valid;
//                                  m_tlast = arc_done
//
// Every input transfer yields exactly one result transfer, through the output register.
// The arc walk (one error update and a reciprocal divide by ten) is a single
// combinational pass, so one item can be taken in every cycle while s_tready is high.
// Reset (rst, synchronous, active high) ends any running arc and empties the output.
// A two-entry output register lets one more item enter while a result is stalled;
// input ready drops only when both entries are full.
module half_circle_point_generator
  import hcpg_pkg::*;
#(
  parameter int COORD_BITS = 9
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // Fields from bit 0: corner_left, corner_bottom, corner_right, corner_top,
  // mirrored, then zero padding. Each corner is COORD_BITS wide.
  input  logic [((4*COORD_BITS+1+7)/8)*8-1:0] s_tdata,
  // Fields from bit 0: req_type (0 = start an arc, 1 = step).
  input  logic [0:0] s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // Fields from bit 0: right_x, left_x, point_y (11 bits each, signed), padding.
  output logic [OUT_TDATA_W-1:0] m_tdata,
  // Fields from bit 0: point_valid.
  output logic [0:0] m_tuser,
  // arc_done: last pair of the arc, or no arc running.
  output logic m_tlast
);

  localparam int N = COORD_BITS;

  logic    accept;
  logic    pop;
  logic    skid_valid;
  result_t new_res;
  result_t out_res;
  result_t skid_res;

  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;
  assign pop      = m_tvalid && m_tready;

  hcpg_walker #(
    .COORD_BITS(COORD_BITS)
  ) u_walker (
    .clk          (clk),
    .rst          (rst),
    .take         (accept),
    .req_type     (req_kind_t'(s_tuser[0])),
    .corner_left  (s_tdata[N-1:0]),
    .corner_bottom(s_tdata[2*N-1:N]),
    .corner_right (s_tdata[3*N-1:2*N]),
    .corner_top   (s_tdata[4*N-1:3*N]),
    .mirrored     (s_tdata[4*N]),
    .result       (new_res)
  );

  // Control of the output register and the skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!m_tvalid || pop) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload moves without reset; the valid flags above qualify it.
  always_ff @(posedge clk) begin
    if (!m_tvalid || pop) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (accept) begin
        out_res <= new_res;
      end
    end else if (accept) begin
      skid_res <= new_res;
    end
  end

  assign m_tdata = {{(OUT_TDATA_W - 3*OUT_W){1'b0}},
                    out_res.point_y, out_res.left_x, out_res.right_x};
  assign m_tuser = out_res.point_valid;
  assign m_tlast = out_res.arc_done;

  // The skid entry is only ever filled behind a full output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid entry holds data while the output register is empty");

  // A result without a point pair always closes the arc.
  a_empty_is_done: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> m_tlast)
    else $error("result without a point pair is not marked done");

  // An item taken while the output is stalled must land in the skid entry.
  a_stall_fills_skid: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready && accept) |=> skid_valid)
    else $error("item accepted during an output stall was dropped");

endmodule

>>> test/arc_point_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the half circle generator, predicts every result
// from the accepted input transfers and compares the results in order.
module arc_point_checker
  import hcpg_pkg::*;
#(
  parameter int CB   = 9,
  parameter int IN_W = ((4*CB+1+7)/8)*8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [IN_W-1:0]        s_tdata,
  input  logic [0:0]             s_tuser,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic [0:0]             m_tuser,
  input  logic                   m_tlast,
  output int                     fails,
  output int                     outstanding
);

  // Walk state. Kept as plain integers so the arithmetic never wraps.
  int   centre_x;
  int   base_row;
  int   walk_x;
  int   walk_y;
  int   walk_err;
  logic arc_mirrored;
  logic arc_running;

  result_t pending_pairs[$];
  result_t seen;
  result_t want;

  function automatic result_t next_point_pair(input logic kind, input logic [IN_W-1:0] data);
    int lft, bot, rgt, tp, radius, row, err2;
    result_t pair;
    pair = '0;
    pair.arc_done = 1'b1;
    if (kind == REQ_START) begin
      lft = int'(data[0*CB +: CB]);
      bot = int'(data[1*CB +: CB]);
      rgt = int'(data[2*CB +: CB]);
      tp  = int'(data[3*CB +: CB]);
      // Signed division truncates toward zero, so right = left - 1 gives radius zero.
      radius = (rgt - lft) / 2;
      arc_mirrored = data[4*CB];
      centre_x = (lft + rgt) / 2;
      base_row = arc_mirrored ? bot : tp;
      walk_x = 0;
      walk_err = 0;
      if (radius < 0) begin
        arc_running = 1'b0;
        walk_y = 0;
        return pair;
      end
      walk_y = radius;
      walk_err = 2 - 2 * radius;
      arc_running = 1'b1;
    end else if (!arc_running) begin
      return pair;
    end

    // Vertical squash by 7/10: floor going up, ceiling going down.
    if (arc_mirrored) row = base_row + (7 * walk_y) / 10;
    else row = base_row - (7 * walk_y + 9) / 10;

    pair.right_x = OUT_W'(centre_x + walk_x);
    pair.left_x = OUT_W'(centre_x - walk_x);
    pair.point_y = OUT_W'(row);
    pair.point_valid = 1'b1;

    // One iteration of the circle error walk.
    err2 = 2 * (walk_err + walk_y) - 1;
    if (walk_err < 0 && err2 <= 0) begin
      walk_x++;
      walk_err += 2 * walk_x + 1;
    end else begin
      err2 = 2 * (walk_err - walk_x) - 1;
      if (walk_err > 0 && err2 > 0) begin
        walk_y--;
        walk_err += 1 - 2 * walk_y;
      end else begin
        walk_x++;
        walk_err += 2 * (walk_x - walk_y);
        walk_y--;
      end
    end

    pair.arc_done = (walk_y < 0);
    if (walk_y < 0) arc_running = 1'b0;
    return pair;
  endfunction

  task automatic check_field(input string name, input logic [OUT_W-1:0] exp_v,
                             input logic [OUT_W-1:0] got_v, input bit is_coord);
    if (got_v !== exp_v) begin
      fails++;
      if (is_coord) begin
        $error("%s: expected %0d, got %0d", name, $signed(exp_v), $signed(got_v));
      end else begin
        $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      end
    end
  endtask

  initial begin
    fails = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      centre_x = 0;
      base_row = 0;
      walk_x = 0;
      walk_y = 0;
      walk_err = 0;
      arc_mirrored = 1'b0;
      arc_running = 1'b0;
      pending_pairs.delete();
    end else begin
      // Results come out no earlier than the cycle after their item, so the
      // result side is settled before this edge's input is predicted.
      if (m_tvalid && m_tready) begin
        seen.right_x = m_tdata[0*OUT_W +: OUT_W];
        seen.left_x = m_tdata[1*OUT_W +: OUT_W];
        seen.point_y = m_tdata[2*OUT_W +: OUT_W];
        seen.point_valid = m_tuser[0];
        seen.arc_done = m_tlast;
        if (pending_pairs.size() == 0) begin
          fails++;
          $error("result transfer with no expected result waiting");
        end else begin
          want = pending_pairs.pop_front();
          check_field("right_x", want.right_x, seen.right_x, 1'b1);
          check_field("left_x", want.left_x, seen.left_x, 1'b1);
          check_field("point_y", want.point_y, seen.point_y, 1'b1);
          check_field("point_valid", OUT_W'(want.point_valid), OUT_W'(seen.point_valid), 1'b0);
          check_field("arc_done", OUT_W'(want.arc_done), OUT_W'(seen.arc_done), 1'b0);
        end
      end
      if (s_tvalid && s_tready) begin
        pending_pairs.push_back(next_point_pair(s_tuser[0], s_tdata));
      end
    end
    outstanding <= pending_pairs.size();
  end

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the half circle point generator. The checker
// instance beside the block does all prediction and comparison.
module testbench;
  import hcpg_pkg::*;

  localparam int CB = 9;
  localparam int IN_W = ((4*CB+1+7)/8)*8;
  localparam int PHASE_ITEMS = 433;
  localparam int HOLD_CYCLES = 300;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_W-1:0]        s_tdata;
  logic [0:0]             s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [0:0]             m_tuser;
  logic                   m_tlast;

  int fails;
  int outstanding;

  // Idle rates in percent for the sender and the receiver of the current phase.
  int send_idle_pct;
  int recv_idle_pct;

  // A long receiver hold-off is requested by bumping hold_requests; the
  // receiver process counts the cycles itself and then bumps holds_served.
  int hold_requests;
  int holds_served;
  int hold_left;

  int items_sent;

  half_circle_point_generator #(.COORD_BITS(CB)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  arc_point_checker #(.CB(CB), .IN_W(IN_W)) u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .fails       (fails),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver: random back-pressure, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
      if (hold_left == 0) holds_served++;
    end else if (holds_served != hold_requests) begin
      hold_left = HOLD_CYCLES - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offers one item and returns at the edge where its transfer happens.
  // Valid stays high afterwards so back-to-back items need no toggle.
  task automatic offer(input req_kind_t kind, input logic [CB-1:0] lft, bot, rgt, tp,
                       input logic mir);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= IN_W'({mir, tp, rgt, bot, lft});
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  // A start followed by a number of steps. Step items carry random corner
  // bits, which the block must ignore.
  task automatic run_arc(input logic [CB-1:0] lft, bot, rgt, tp, input logic mir,
                         input int steps);
    offer(REQ_START, lft, bot, rgt, tp, mir);
    repeat (steps) begin
      offer(REQ_STEP, CB'($urandom), CB'($urandom), CB'($urandom), CB'($urandom),
            1'($urandom));
    end
  endtask

  // Stops offering until every expected result has come back.
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Mostly small boxes walked to the end, with some medium and some nearly
  // full-width ones; a share of arcs is cut short by the next start, and
  // arbitrary corner pairs cover the reversed boxes that yield no arc.
  task automatic random_arc();
    int pick, span, radius, steps;
    logic [CB-1:0] lft, rgt;
    pick = $urandom_range(99);
    if (pick < 80) begin
      span = $urandom_range(40);
      lft = CB'($urandom_range(511 - span));
      rgt = CB'(lft + span);
    end else if (pick < 88) begin
      span = $urandom_range(160, 41);
      lft = CB'($urandom_range(511 - span));
      rgt = CB'(lft + span);
    end else if (pick < 94) begin
      lft = CB'($urandom);
      rgt = CB'($urandom);
    end else begin
      lft = CB'($urandom_range(20));
      rgt = CB'(511 - $urandom_range(20));
    end
    radius = (int'(rgt) - int'(lft)) / 2;
    if (radius < 0) radius = 0;
    // The walk ends within 2*radius+1 steps, so a few extra steps land on
    // an idle generator.
    if ($urandom_range(9) < 7) steps = 2 * radius + $urandom_range(3);
    else steps = $urandom_range(2 * radius + 1);
    if (steps > 200) steps = $urandom_range(120, 40);
    run_arc(lft, CB'($urandom), rgt, CB'($urandom), 1'($urandom), steps);
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tuser = '0;
    s_tdata = '0;
    m_tready = 1'b0;
    send_idle_pct = 25;
    recv_idle_pct = 51;
    hold_requests = 0;
    holds_served = 0;
    hold_left = 0;
    items_sent = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part.
    // A step right after reset has no arc to advance.
    offer(REQ_STEP, '1, '1, '1, '1, 1'b1);
    // Widest box, hanging down from the top row.
    run_arc(0, 0, 511, 511, 1'b0, 2);
    // Right corner left of the left one by more than one: no arc at all.
    run_arc(511, 0, 0, 0, 1'b1, 1);
    // Right corner one left of the left one: a single pair at the centre.
    run_arc(10, 300, 9, 300, 1'b0, 1);
    // Zero-width box, mirrored.
    run_arc(100, 0, 100, 0, 1'b1, 1);
    // Small arc under row zero, so the rows go negative; walked to the end.
    run_arc(0, 5, 4, 0, 1'b0, 5);
    // Mirrored up from the bottom row 511, past the corner range.
    run_arc(0, 511, 511, 0, 1'b1, 2);
    // An arc abandoned by the next start.
    run_arc(200, 50, 230, 400, 1'b1, 2);
    run_arc(511, 511, 511, 511, 1'b1, 1);
    drain();

    // Random part in three idling phases. Each phase opens with a long
    // receiver hold-off while the sender keeps offering, and closes with
    // the sender pausing until everything is back.
    items_sent = 0;
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 25 : (phase == 1) ? 51 : 0;
      recv_idle_pct = (phase == 0) ? 51 : (phase == 1) ? 25 : 0;
      hold_requests++;
      while (items_sent < (phase + 1) * PHASE_ITEMS) random_arc();
      drain();
    end

    // Allow for any late, unexpected result.
    repeat (8) @(posedge clk);
    if (fails == 0) begin
      $display("half_circle_point_generator: match");
    end else begin
      $display("half_circle_point_generator: mismatch");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("half_circle_point_generator: mismatch");
    $finish;
  end

endmodule

>>> filelist.f
src/hcpg_pkg.sv
src/hcpg_walker.sv
src/half_circle_point_generator.sv
test/arc_point_checker.sv
test/testbench.sv
